// ===== rtl/core/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, types and fixed-point helpers of the direction frame
// rotation pipeline.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ONE_Q       = 1 << FRAC_BITS;
  localparam int NINE_TENTHS = (ONE_Q * 9) / 10;

  // Square root unit: 44-bit radicand, one result bit per stage.
  localparam int SQ_IN_W  = 44;
  localparam int SQ_OUT_W = 22;
  localparam int SQRT_LAT = SQ_OUT_W;

  // Divider unit: magnitude shifted up by FRAC_BITS over a norm.
  localparam int DIV_NUM_W = 38;
  localparam int DIV_DEN_W = 22;
  localparam int DIV_Q_W   = FRAC_BITS + 1;
  localparam int DIV_LAT   = DIV_Q_W;

  typedef enum logic [1:0] {
    PATH_NORMAL   = 2'd0,
    PATH_FALLBACK = 2'd1,
    PATH_PARENT   = 2'd2
  } path_t;

  // Everything one word carries down the pipeline.
  typedef struct packed {
    logic                      inv;
    logic signed [18:0]        lx;
    logic signed [18:0]        ly;
    logic signed [18:0]        lz;
    logic signed [17:0]        px;
    logic signed [17:0]        py;
    logic signed [17:0]        pz;
    logic [DIV_DEN_W-1:0]      nrm;
    logic signed [17:0]        wx;
    logic signed [17:0]        wy;
    logic signed [17:0]        wz;
    logic                      refx;
    logic signed [18:0]        ux;
    logic signed [18:0]        uy;
    logic signed [18:0]        uz;
    logic signed [18:0]        vx;
    logic signed [18:0]        vy;
    logic signed [18:0]        vz;
    logic signed [21:0]        ox;
    logic signed [21:0]        oy;
    logic signed [21:0]        oz;
    logic [2:0][SQ_IN_W-1:0]   sq;
    logic [8:0][23:0]          mp;
    logic signed [17:0]        fx;
    logic signed [17:0]        fy;
    logic signed [17:0]        fz;
    path_t                     path;
  } ctx_t;

  function automatic logic [21:0] mag22(input logic signed [21:0] a);
    mag22 = a[21] ? 22'(-a) : 22'(a);
  endfunction

  // Fixed-point product, truncated toward zero.
  function automatic logic signed [23:0] mulq(input logic signed [21:0] a,
                                              input logic signed [19:0] b);
    logic [21:0] ma;
    logic [19:0] mb;
    logic [41:0] pr;
    logic [23:0] r;
    ma = mag22(a);
    mb = b[19] ? 20'(-b) : 20'(b);
    pr = 42'(ma) * 42'(mb);
    r  = pr[FRAC_BITS+23:FRAC_BITS];
    mulq = (a[21] != b[19]) ? $signed(24'(-r)) : $signed(r);
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
    if (v > 20'sd131071) begin
      sat18 = 18'sd131071;
    end else if (v < -20'sd131072) begin
      sat18 = -18'sd131072;
    end else begin
      sat18 = 18'(v);
    end
  endfunction

endpackage

// ===== rtl/core/dfr_isqrt.sv =====
// ----------------------------------------------------------------------------
// dfr_isqrt
// Pipelined integer square root (floor), one result bit per stage.
// ----------------------------------------------------------------------------
module dfr_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dfr_pkg::SQ_IN_W-1:0]   x,
  output logic [dfr_pkg::SQ_OUT_W-1:0]  root
);

  logic [45:0] rem_r  [dfr_pkg::SQRT_LAT];
  logic [45:0] rem_nxt[dfr_pkg::SQRT_LAT];
  logic [45:0] res_r  [dfr_pkg::SQRT_LAT];
  logic [45:0] res_nxt[dfr_pkg::SQRT_LAT];

  // The remainder holds x minus the square of the bits found so far.
  always_comb begin
    logic [45:0] rem_in;
    logic [45:0] res_in;
    logic [45:0] trial;
    for (int s = 0; s < dfr_pkg::SQRT_LAT; s++) begin
      rem_in = (s == 0) ? 46'(x) : rem_r[(s == 0) ? 0 : s - 1];
      res_in = (s == 0) ? 46'd0 : res_r[(s == 0) ? 0 : s - 1];
      trial  = (res_in << (dfr_pkg::SQRT_LAT - s))
             + (46'd1 << (2 * (dfr_pkg::SQRT_LAT - 1 - s)));
      if (rem_in >= trial) begin
        rem_nxt[s] = rem_in - trial;
        res_nxt[s] = res_in | (46'd1 << (dfr_pkg::SQRT_LAT - 1 - s));
      end else begin
        rem_nxt[s] = rem_in;
        res_nxt[s] = res_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      res_r <= res_nxt;
    end
  end

  assign root = res_r[dfr_pkg::SQRT_LAT-1][dfr_pkg::SQ_OUT_W-1:0];

endmodule

// ===== rtl/core/dfr_div.sv =====
// ----------------------------------------------------------------------------
// dfr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dfr_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [dfr_pkg::DIV_NUM_W-1:0]  num,
  input  logic [dfr_pkg::DIV_DEN_W-1:0]  den,
  output logic [dfr_pkg::DIV_Q_W-1:0]    quo
);

  logic [39:0]                     rem_r  [dfr_pkg::DIV_LAT];
  logic [39:0]                     rem_nxt[dfr_pkg::DIV_LAT];
  logic [dfr_pkg::DIV_Q_W-1:0]     q_r    [dfr_pkg::DIV_LAT];
  logic [dfr_pkg::DIV_Q_W-1:0]     q_nxt  [dfr_pkg::DIV_LAT];
  logic [dfr_pkg::DIV_DEN_W-1:0]   d_r    [dfr_pkg::DIV_LAT];
  logic [dfr_pkg::DIV_DEN_W-1:0]   d_nxt  [dfr_pkg::DIV_LAT];

  // The quotient stays below 2^DIV_Q_W because the magnitude shifted into the
  // numerator never exceeds the norm it is divided by.
  always_comb begin
    logic [39:0]                   rem_in;
    logic [dfr_pkg::DIV_Q_W-1:0]   q_in;
    logic [dfr_pkg::DIV_DEN_W-1:0] d_in;
    logic [39:0]                   sub;
    for (int s = 0; s < dfr_pkg::DIV_LAT; s++) begin
      rem_in = (s == 0) ? 40'(num) : rem_r[(s == 0) ? 0 : s - 1];
      q_in   = (s == 0) ? '0 : q_r[(s == 0) ? 0 : s - 1];
      d_in   = (s == 0) ? den : d_r[(s == 0) ? 0 : s - 1];
      sub    = 40'(d_in) << (dfr_pkg::DIV_LAT - 1 - s);
      d_nxt[s] = d_in;
      if (rem_in >= sub) begin
        rem_nxt[s] = rem_in - sub;
        q_nxt[s]   = q_in | (dfr_pkg::DIV_Q_W'(1) << (dfr_pkg::DIV_LAT - 1 - s));
      end else begin
        rem_nxt[s] = rem_in;
        q_nxt[s]   = q_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      d_r   <= d_nxt;
    end
  end

  assign quo = q_r[dfr_pkg::DIV_LAT-1];

endmodule

// ===== rtl/core/direction_frame_rotation.sv =====
// ----------------------------------------------------------------------------
// direction_frame_rotation
// Rotates a local direction into the orthonormal frame of a parent direction.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output side does not stall and
// returns one word per input, in order. The depth of the pipeline is set by
// the three norm computations, each a 22-stage square root followed by a
// 17-stage divider, plus the product and sum stages between them. The whole
// pipeline advances whenever the output register is empty or being read, so
// a stall on the output holds every stage in place.
module direction_frame_rotation (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // local_x, local_y, local_z, parent_x, parent_y, parent_z, zero pad
  input  logic [111:0] in_tdata,
  // local_invalid
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, zero pad
  output logic [55:0]  out_tdata,
  // path_taken
  output logic [1:0]   out_tuser
);

  localparam int L      = dfr_pkg::SQRT_LAT;
  localparam int D      = dfr_pkg::DIV_LAT;
  localparam int P_SQ   = 1;
  localparam int P_SUM  = 2;
  localparam int P_NA   = P_SUM + L + 1;
  localparam int P_W    = P_NA + D + 1;
  localparam int P_PR   = P_W + 1;
  localparam int P_U    = P_PR + 1;
  localparam int P_USQ  = P_U + 1;
  localparam int P_USUM = P_USQ + 1;
  localparam int P_NU   = P_USUM + L + 1;
  localparam int P_UN   = P_NU + D + 1;
  localparam int P_VP   = P_UN + 1;
  localparam int P_V    = P_VP + 1;
  localparam int P_OP   = P_V + 1;
  localparam int P_O    = P_OP + 1;
  localparam int P_OSQ  = P_O + 1;
  localparam int P_OSUM = P_OSQ + 1;
  localparam int P_NO   = P_OSUM + L + 1;
  localparam int P_FIN  = P_NO + D + 1;
  localparam int NSTAGE = P_FIN + 1;

  dfr_pkg::ctx_t pipe_r  [NSTAGE];
  dfr_pkg::ctx_t pipe_nxt[NSTAGE];
  logic [NSTAGE-1:0] valid_r;
  logic              adv;

  logic [dfr_pkg::SQ_OUT_W-1:0] root_a, root_u, root_o;
  logic [dfr_pkg::DIV_Q_W-1:0]  qa [3];
  logic [dfr_pkg::DIV_Q_W-1:0]  qu [3];
  logic [dfr_pkg::DIV_Q_W-1:0]  qo [3];
  logic [dfr_pkg::DIV_NUM_W-1:0] na [3];
  logic [dfr_pkg::DIV_NUM_W-1:0] nu [3];
  logic [dfr_pkg::DIV_NUM_W-1:0] no [3];

  assign adv       = !valid_r[NSTAGE-1] || out_tready;
  assign in_tready = adv;

  // Divider numerators: magnitudes shifted up by the fraction width.
  always_comb begin
    na[0] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(22'(pipe_r[P_NA].px))) << dfr_pkg::FRAC_BITS;
    na[1] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(22'(pipe_r[P_NA].py))) << dfr_pkg::FRAC_BITS;
    na[2] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(22'(pipe_r[P_NA].pz))) << dfr_pkg::FRAC_BITS;
    nu[0] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(22'(pipe_r[P_NU].ux))) << dfr_pkg::FRAC_BITS;
    nu[1] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(22'(pipe_r[P_NU].uy))) << dfr_pkg::FRAC_BITS;
    nu[2] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(22'(pipe_r[P_NU].uz))) << dfr_pkg::FRAC_BITS;
    no[0] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(pipe_r[P_NO].ox)) << dfr_pkg::FRAC_BITS;
    no[1] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(pipe_r[P_NO].oy)) << dfr_pkg::FRAC_BITS;
    no[2] = dfr_pkg::DIV_NUM_W'(dfr_pkg::mag22(pipe_r[P_NO].oz)) << dfr_pkg::FRAC_BITS;
  end

  dfr_isqrt u_sqrt_a (.clk(clk), .en(adv), .x(pipe_r[P_SUM].sq[0]), .root(root_a));
  dfr_isqrt u_sqrt_u (.clk(clk), .en(adv), .x(pipe_r[P_USUM].sq[0]), .root(root_u));
  dfr_isqrt u_sqrt_o (.clk(clk), .en(adv), .x(pipe_r[P_OSUM].sq[0]), .root(root_o));

  for (genvar g = 0; g < 3; g++) begin : g_div
    dfr_div u_div_a (.clk(clk), .en(adv), .num(na[g]), .den(pipe_r[P_NA].nrm), .quo(qa[g]));
    dfr_div u_div_u (.clk(clk), .en(adv), .num(nu[g]), .den(pipe_r[P_NU].nrm), .quo(qu[g]));
    dfr_div u_div_o (.clk(clk), .en(adv), .num(no[g]), .den(pipe_r[P_NO].nrm), .quo(qo[g]));
  end

  always_comb begin
    logic signed [18:0] zc;
    logic [21:0]        m0, m1, m2;
    logic signed [17:0] proj;

    for (int i = 1; i < NSTAGE; i++) begin
      pipe_nxt[i] = pipe_r[i-1];
    end

    // Input capture.
    pipe_nxt[0]     = '0;
    pipe_nxt[0].lx  = $signed(in_tdata[18:0]);
    pipe_nxt[0].ly  = $signed(in_tdata[37:19]);
    pipe_nxt[0].lz  = $signed(in_tdata[56:38]);
    pipe_nxt[0].px  = $signed(in_tdata[74:57]);
    pipe_nxt[0].py  = $signed(in_tdata[92:75]);
    pipe_nxt[0].pz  = $signed(in_tdata[110:93]);
    pipe_nxt[0].inv = in_tuser[0];

    // Parent norm.
    m0 = dfr_pkg::mag22(22'(pipe_r[P_SQ-1].px));
    m1 = dfr_pkg::mag22(22'(pipe_r[P_SQ-1].py));
    m2 = dfr_pkg::mag22(22'(pipe_r[P_SQ-1].pz));
    pipe_nxt[P_SQ].sq[0] = dfr_pkg::SQ_IN_W'(m0) * dfr_pkg::SQ_IN_W'(m0);
    pipe_nxt[P_SQ].sq[1] = dfr_pkg::SQ_IN_W'(m1) * dfr_pkg::SQ_IN_W'(m1);
    pipe_nxt[P_SQ].sq[2] = dfr_pkg::SQ_IN_W'(m2) * dfr_pkg::SQ_IN_W'(m2);
    pipe_nxt[P_SUM].sq[0] = pipe_r[P_SUM-1].sq[0] + pipe_r[P_SUM-1].sq[1]
                          + pipe_r[P_SUM-1].sq[2];
    pipe_nxt[P_NA].nrm = root_a;

    // Unit parent w; a zero parent points along z.
    if (pipe_r[P_W-1].nrm == '0) begin
      pipe_nxt[P_W].wx = '0;
      pipe_nxt[P_W].wy = '0;
      pipe_nxt[P_W].wz = 18'(dfr_pkg::ONE_Q);
    end else begin
      pipe_nxt[P_W].wx = pipe_r[P_W-1].px[17] ? 18'(-$signed({1'b0, qa[0]})) : 18'(qa[0]);
      pipe_nxt[P_W].wy = pipe_r[P_W-1].py[17] ? 18'(-$signed({1'b0, qa[1]})) : 18'(qa[1]);
      pipe_nxt[P_W].wz = pipe_r[P_W-1].pz[17] ? 18'(-$signed({1'b0, qa[2]})) : 18'(qa[2]);
    end

    // Reference axis and projection onto w.
    pipe_nxt[P_PR].refx = dfr_pkg::mag22(22'(pipe_r[P_PR-1].wx)) < 22'(dfr_pkg::NINE_TENTHS);
    proj = pipe_nxt[P_PR].refx ? pipe_r[P_PR-1].wx : pipe_r[P_PR-1].wy;
    pipe_nxt[P_PR].mp[0] = dfr_pkg::mulq(22'(proj), 20'(pipe_r[P_PR-1].wx));
    pipe_nxt[P_PR].mp[1] = dfr_pkg::mulq(22'(proj), 20'(pipe_r[P_PR-1].wy));
    pipe_nxt[P_PR].mp[2] = dfr_pkg::mulq(22'(proj), 20'(pipe_r[P_PR-1].wz));

    pipe_nxt[P_U].ux = 19'((pipe_r[P_U-1].refx ? 25'sd65536 : 25'sd0)
                           - 25'($signed(pipe_r[P_U-1].mp[0])));
    pipe_nxt[P_U].uy = 19'((pipe_r[P_U-1].refx ? 25'sd0 : 25'sd65536)
                           - 25'($signed(pipe_r[P_U-1].mp[1])));
    pipe_nxt[P_U].uz = 19'(-25'($signed(pipe_r[P_U-1].mp[2])));

    // Norm of u.
    m0 = dfr_pkg::mag22(22'(pipe_r[P_USQ-1].ux));
    m1 = dfr_pkg::mag22(22'(pipe_r[P_USQ-1].uy));
    m2 = dfr_pkg::mag22(22'(pipe_r[P_USQ-1].uz));
    pipe_nxt[P_USQ].sq[0] = dfr_pkg::SQ_IN_W'(m0) * dfr_pkg::SQ_IN_W'(m0);
    pipe_nxt[P_USQ].sq[1] = dfr_pkg::SQ_IN_W'(m1) * dfr_pkg::SQ_IN_W'(m1);
    pipe_nxt[P_USQ].sq[2] = dfr_pkg::SQ_IN_W'(m2) * dfr_pkg::SQ_IN_W'(m2);
    pipe_nxt[P_USUM].sq[0] = pipe_r[P_USUM-1].sq[0] + pipe_r[P_USUM-1].sq[1]
                           + pipe_r[P_USUM-1].sq[2];
    pipe_nxt[P_NU].nrm = root_u;

    // A degenerate u falls back to the bare reference axis.
    if (pipe_r[P_UN-1].nrm == '0) begin
      pipe_nxt[P_UN].ux = pipe_r[P_UN-1].refx ? 19'sd65536 : 19'sd0;
      pipe_nxt[P_UN].uy = pipe_r[P_UN-1].refx ? 19'sd0 : 19'sd65536;
      pipe_nxt[P_UN].uz = '0;
    end else begin
      pipe_nxt[P_UN].ux = pipe_r[P_UN-1].ux[18] ? 19'(-$signed({1'b0, qu[0]})) : 19'(qu[0]);
      pipe_nxt[P_UN].uy = pipe_r[P_UN-1].uy[18] ? 19'(-$signed({1'b0, qu[1]})) : 19'(qu[1]);
      pipe_nxt[P_UN].uz = pipe_r[P_UN-1].uz[18] ? 19'(-$signed({1'b0, qu[2]})) : 19'(qu[2]);
    end

    // v = w cross u.
    pipe_nxt[P_VP].mp[0] = dfr_pkg::mulq(22'(pipe_r[P_VP-1].wy), 20'(pipe_r[P_VP-1].uz));
    pipe_nxt[P_VP].mp[1] = dfr_pkg::mulq(22'(pipe_r[P_VP-1].wz), 20'(pipe_r[P_VP-1].uy));
    pipe_nxt[P_VP].mp[2] = dfr_pkg::mulq(22'(pipe_r[P_VP-1].wz), 20'(pipe_r[P_VP-1].ux));
    pipe_nxt[P_VP].mp[3] = dfr_pkg::mulq(22'(pipe_r[P_VP-1].wx), 20'(pipe_r[P_VP-1].uz));
    pipe_nxt[P_VP].mp[4] = dfr_pkg::mulq(22'(pipe_r[P_VP-1].wx), 20'(pipe_r[P_VP-1].uy));
    pipe_nxt[P_VP].mp[5] = dfr_pkg::mulq(22'(pipe_r[P_VP-1].wy), 20'(pipe_r[P_VP-1].ux));
    pipe_nxt[P_V].vx = 19'($signed(pipe_r[P_V-1].mp[0]) - $signed(pipe_r[P_V-1].mp[1]));
    pipe_nxt[P_V].vy = 19'($signed(pipe_r[P_V-1].mp[2]) - $signed(pipe_r[P_V-1].mp[3]));
    pipe_nxt[P_V].vz = 19'($signed(pipe_r[P_V-1].mp[4]) - $signed(pipe_r[P_V-1].mp[5]));

    // Rotation into the frame.
    pipe_nxt[P_OP].mp[0] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].lx), 20'(pipe_r[P_OP-1].ux));
    pipe_nxt[P_OP].mp[1] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].ly), 20'(pipe_r[P_OP-1].vx));
    pipe_nxt[P_OP].mp[2] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].lz), 20'(pipe_r[P_OP-1].wx));
    pipe_nxt[P_OP].mp[3] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].lx), 20'(pipe_r[P_OP-1].uy));
    pipe_nxt[P_OP].mp[4] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].ly), 20'(pipe_r[P_OP-1].vy));
    pipe_nxt[P_OP].mp[5] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].lz), 20'(pipe_r[P_OP-1].wy));
    pipe_nxt[P_OP].mp[6] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].lx), 20'(pipe_r[P_OP-1].uz));
    pipe_nxt[P_OP].mp[7] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].ly), 20'(pipe_r[P_OP-1].vz));
    pipe_nxt[P_OP].mp[8] = dfr_pkg::mulq(22'(pipe_r[P_OP-1].lz), 20'(pipe_r[P_OP-1].wz));
    pipe_nxt[P_O].ox = 22'($signed(pipe_r[P_O-1].mp[0]) + $signed(pipe_r[P_O-1].mp[1])
                           + $signed(pipe_r[P_O-1].mp[2]));
    pipe_nxt[P_O].oy = 22'($signed(pipe_r[P_O-1].mp[3]) + $signed(pipe_r[P_O-1].mp[4])
                           + $signed(pipe_r[P_O-1].mp[5]));
    pipe_nxt[P_O].oz = 22'($signed(pipe_r[P_O-1].mp[6]) + $signed(pipe_r[P_O-1].mp[7])
                           + $signed(pipe_r[P_O-1].mp[8]));

    // Norm of the rotated vector.
    m0 = dfr_pkg::mag22(pipe_r[P_OSQ-1].ox);
    m1 = dfr_pkg::mag22(pipe_r[P_OSQ-1].oy);
    m2 = dfr_pkg::mag22(pipe_r[P_OSQ-1].oz);
    pipe_nxt[P_OSQ].sq[0] = dfr_pkg::SQ_IN_W'(m0) * dfr_pkg::SQ_IN_W'(m0);
    pipe_nxt[P_OSQ].sq[1] = dfr_pkg::SQ_IN_W'(m1) * dfr_pkg::SQ_IN_W'(m1);
    pipe_nxt[P_OSQ].sq[2] = dfr_pkg::SQ_IN_W'(m2) * dfr_pkg::SQ_IN_W'(m2);
    pipe_nxt[P_OSUM].sq[0] = pipe_r[P_OSUM-1].sq[0] + pipe_r[P_OSUM-1].sq[1]
                           + pipe_r[P_OSUM-1].sq[2];
    pipe_nxt[P_NO].nrm = root_o;

    // Final selection among the three outcomes.
    zc = pipe_r[P_FIN-1].lz;
    if (zc > 19'sd65536) begin
      zc = 19'sd65536;
    end
    if (zc < -19'sd65536) begin
      zc = -19'sd65536;
    end
    if (pipe_r[P_FIN-1].pz[17]) begin
      zc = -zc;
    end
    if (pipe_r[P_FIN-1].inv) begin
      pipe_nxt[P_FIN].fx   = '0;
      pipe_nxt[P_FIN].fy   = '0;
      pipe_nxt[P_FIN].fz   = dfr_pkg::sat18(20'(zc));
      pipe_nxt[P_FIN].path = dfr_pkg::PATH_FALLBACK;
    end else if (pipe_r[P_FIN-1].nrm == '0) begin
      pipe_nxt[P_FIN].fx   = pipe_r[P_FIN-1].px;
      pipe_nxt[P_FIN].fy   = pipe_r[P_FIN-1].py;
      pipe_nxt[P_FIN].fz   = pipe_r[P_FIN-1].pz;
      pipe_nxt[P_FIN].path = dfr_pkg::PATH_PARENT;
    end else begin
      pipe_nxt[P_FIN].fx = dfr_pkg::sat18(pipe_r[P_FIN-1].ox[21]
                             ? 20'(-$signed({1'b0, qo[0]})) : 20'(qo[0]));
      pipe_nxt[P_FIN].fy = dfr_pkg::sat18(pipe_r[P_FIN-1].oy[21]
                             ? 20'(-$signed({1'b0, qo[1]})) : 20'(qo[1]));
      pipe_nxt[P_FIN].fz = dfr_pkg::sat18(pipe_r[P_FIN-1].oz[21]
                             ? 20'(-$signed({1'b0, qo[2]})) : 20'(qo[2]));
      pipe_nxt[P_FIN].path = dfr_pkg::PATH_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NSTAGE-2:0], in_tvalid};
    end
  end

  assign out_tvalid = valid_r[NSTAGE-1];
  assign out_tdata  = {2'b00, pipe_r[NSTAGE-1].fz, pipe_r[NSTAGE-1].fy,
                       pipe_r[NSTAGE-1].fx};
  assign out_tuser  = pipe_r[NSTAGE-1].path;

  // The fallback path never carries lateral components.
  a_fallback_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dfr_pkg::PATH_FALLBACK) |->
      (out_tdata[17:0] == '0) && (out_tdata[35:18] == '0))
    else $error("fallback word has nonzero x or y");

  // A normalized result never takes its x or z component out of the unit range.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == dfr_pkg::PATH_NORMAL) |->
      ($signed(out_tdata[17:0]) <= 18'sd65536) && ($signed(out_tdata[17:0]) >= -18'sd65536)
      && ($signed(out_tdata[53:36]) <= 18'sd65536)
      && ($signed(out_tdata[53:36]) >= -18'sd65536))
    else $error("normalized component out of range");

  // Input back-pressure only comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without an output stall");

  // While stalled, the pipeline occupancy does not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("pipeline moved during a stall");

endmodule

// ===== sim/tb_direction_frame_rotation.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direction_frame_rotation
// Drives local and parent directions into the frame rotation pipeline with
// random gaps on both sides. Every result word is checked against an in-bench
// fixed-point predictor or, for the plain cases, against typed-in values.
// ----------------------------------------------------------------------------
module tb_direction_frame_rotation;

  localparam int NUM_RANDOM = 600;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint ONE = 65536;

  typedef struct {
    logic signed [18:0] lx, ly, lz;
    logic               inv;
    logic signed [17:0] px, py, pz;
  } dir_word_t;

  typedef struct {
    logic signed [17:0] x, y, z;
    dfr_pkg::path_t     path;
  } rot_word_t;

  typedef struct {
    dir_word_t d;
    bit        typed;
    rot_word_t r;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [111:0]  in_tdata = '0;
  logic [0:0]    in_tuser = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [55:0]   out_tdata;
  logic [1:0]    out_tuser;

  rot_word_t expected_dirs[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        stim_done = 1'b0;
  int        out_hold = 0;

  always #5 clk = ~clk;

  direction_frame_rotation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic longint qmul(longint a, longint b);
    longint r;
    r = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> 16;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint qdiv(longint a, longint n);
    longint r;
    r = ((a < 0 ? -a : a) <<< 16) / n;
    return a < 0 ? -r : r;
  endfunction

  function automatic longint isqrt(longint x);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [17:0] clamp18(longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return 18'(v);
  endfunction

  function automatic rot_word_t rotate_to_parent(dir_word_t d);
    rot_word_t res;
    longint l[3], p[3], w[3], rf[3], u[3], v[3], o[3];
    longint n, z, proj;
    l = '{longint'(d.lx), longint'(d.ly), longint'(d.lz)};
    p = '{longint'(d.px), longint'(d.py), longint'(d.pz)};
    if (d.inv) begin
      z = l[2];
      if (z > ONE) z = ONE;
      if (z < -ONE) z = -ONE;
      if (p[2] < 0) z = -z;
      res.x = '0;
      res.y = '0;
      res.z = clamp18(z);
      res.path = dfr_pkg::PATH_FALLBACK;
      return res;
    end
    n = isqrt(p[0] * p[0] + p[1] * p[1] + p[2] * p[2]);
    if (n == 0) w = '{0, 0, ONE};
    else for (int i = 0; i < 3; i++) w[i] = qdiv(p[i], n);
    rf = '{0, 0, 0};
    if ((w[0] < 0 ? -w[0] : w[0]) < (ONE * 9) / 10) rf[0] = ONE;
    else rf[1] = ONE;
    proj = rf[0] != 0 ? w[0] : w[1];
    for (int i = 0; i < 3; i++) u[i] = rf[i] - qmul(proj, w[i]);
    n = isqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
    if (n == 0) u = rf;
    else for (int i = 0; i < 3; i++) u[i] = qdiv(u[i], n);
    v[0] = qmul(w[1], u[2]) - qmul(w[2], u[1]);
    v[1] = qmul(w[2], u[0]) - qmul(w[0], u[2]);
    v[2] = qmul(w[0], u[1]) - qmul(w[1], u[0]);
    for (int i = 0; i < 3; i++) o[i] = qmul(l[0], u[i]) + qmul(l[1], v[i]) + qmul(l[2], w[i]);
    n = isqrt(o[0] * o[0] + o[1] * o[1] + o[2] * o[2]);
    if (n == 0) begin
      res.x = clamp18(p[0]);
      res.y = clamp18(p[1]);
      res.z = clamp18(p[2]);
      res.path = dfr_pkg::PATH_PARENT;
    end else begin
      res.x = clamp18(qdiv(o[0], n));
      res.y = clamp18(qdiv(o[1], n));
      res.z = clamp18(qdiv(o[2], n));
      res.path = dfr_pkg::PATH_NORMAL;
    end
    return res;
  endfunction

  function automatic dir_row_t mk(int lx, int ly, int lz, bit inv, int px, int py, int pz,
                                  bit typed = 1'b0, int ex = 0, int ey = 0, int ez = 0,
                                  dfr_pkg::path_t ep = dfr_pkg::PATH_NORMAL);
    dir_row_t r;
    r.d.lx = 19'(lx); r.d.ly = 19'(ly); r.d.lz = 19'(lz); r.d.inv = inv;
    r.d.px = 18'(px); r.d.py = 18'(py); r.d.pz = 18'(pz);
    r.typed = typed;
    r.r.x = 18'(ex); r.r.y = 18'(ey); r.r.z = 18'(ez); r.r.path = ep;
    return r;
  endfunction

  // Valid stays high between words that follow with no gap.
  task automatic send_dir(dir_word_t d, rot_word_t want);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, d.pz, d.py, d.px, d.lz, d.ly, d.lx};
    in_tuser  <= d.inv;
    expected_dirs.push_back(want);
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic dir_word_t random_dir();
    dir_word_t d;
    int sel;
    d.lx = 19'($urandom); d.ly = 19'($urandom); d.lz = 19'($urandom);
    d.inv = ($urandom_range(0, 9) == 0);
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // Mostly directions within the legal parent range.
      d.px = 18'($urandom_range(0, 131072) - 65536);
      d.py = 18'($urandom_range(0, 131072) - 65536);
      d.pz = 18'($urandom_range(0, 131072) - 65536);
    end else if (sel < 8) begin
      d.px = 18'($urandom_range(0, 1) ? 60000 + $urandom_range(0, 5536) : -65536);
      d.py = 18'($urandom_range(0, 2000) - 1000);
      d.pz = 18'($urandom_range(0, 2000) - 1000);
    end else begin
      d.px = 18'($urandom); d.py = 18'($urandom); d.pz = 18'($urandom);
    end
    if ($urandom_range(0, 15) == 0) begin
      d.lx = '0; d.ly = '0; d.lz = '0;
    end
    return d;
  endfunction

  function automatic int draw_hold();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  // Directed rows: results are typed where the arithmetic is exact.
  dir_row_t dir_rows[$];
  initial begin
    dir_rows = '{
      mk(0, 0, 65536, 0, 0, 0, 65536, 1, 0, 0, 65536, dfr_pkg::PATH_NORMAL),
      mk(0, 0, 0, 0, 0, 0, 65536, 1, 0, 0, 65536, dfr_pkg::PATH_PARENT),
      mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, dfr_pkg::PATH_PARENT),
      mk(5, 5, 200000, 1, 0, 0, -3, 1, 0, 0, -65536, dfr_pkg::PATH_FALLBACK),
      mk(5, 5, -262144, 1, 0, 0, 4, 1, 0, 0, -65536, dfr_pkg::PATH_FALLBACK),
      mk(0, 0, 1234, 1, 0, 0, 0, 1, 0, 0, 1234, dfr_pkg::PATH_FALLBACK),
      mk(-262144, 262143, -1, 1, 65536, 65536, -65536, 1, 0, 0, 1, dfr_pkg::PATH_FALLBACK),
      mk(65536, 0, 0, 0, 0, 0, 0),
      mk(0, 65536, 0, 0, 0, 0, 0),
      mk(262143, 262143, 262143, 0, 65536, 65536, 65536),
      mk(-262144, -262144, -262144, 0, -65536, -65536, -65536),
      mk(65536, 0, 0, 0, 65536, 0, 0),
      mk(65536, 65536, 0, 0, -65536, 0, 0),
      mk(0, 65536, 65536, 0, 58982, 1000, 0),
      mk(1000, -2000, 3000, 0, 58981, 28000, 0),
      mk(1, 1, 1, 0, 1, 0, 0),
      mk(100, 200, 300, 0, -131072, 131071, -131072),
      mk(-65536, 0, 0, 0, 0, 65536, 0),
      mk(0, 0, 0, 0, 123, -456, 789, 1, 123, -456, 789, dfr_pkg::PATH_PARENT)
    };
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        send_dir(dir_rows[i].d, dir_rows[i].r);
      end else begin
        send_dir(dir_rows[i].d, rotate_to_parent(dir_rows[i].d));
      end
    end
    in_tvalid <= 1'b0;
    // Drain the pipeline once before the random part.
    while (expected_dirs.size() != 0) @(posedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      dir_word_t d;
      d = random_dir();
      send_dir(d, rotate_to_parent(d));
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Before each result word the receiver holds ready low for a drawn count.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else if (out_tvalid && out_tready) begin
      out_hold = draw_hold();
      out_tready <= (out_hold == 0);
    end else if (!out_tready) begin
      if (out_hold > 0) out_hold = out_hold - 1;
      out_tready <= (out_hold == 0);
    end
  end

  always @(posedge clk) begin
    rot_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_dirs.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = expected_dirs.pop_front();
        if ($signed(out_tdata[17:0]) != want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, $signed(out_tdata[17:0]));
          errors++;
        end
        if ($signed(out_tdata[35:18]) != want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, $signed(out_tdata[35:18]));
          errors++;
        end
        if ($signed(out_tdata[53:36]) != want.z) begin
          $error("out_z: expected %0d, got %0d", want.z, $signed(out_tdata[53:36]));
          errors++;
        end
        if (out_tuser != want.path) begin
          $error("path_taken: expected %0d, got %0d", want.path, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    while (!(stim_done && expected_dirs.size() == 0) && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (300) @(posedge clk);
    if (cycles >= CYCLE_LIMIT || expected_dirs.size() != 0) begin
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

endmodule

// ===== sim.f =====
rtl/core/dfr_pkg.sv
rtl/core/dfr_isqrt.sv
rtl/core/dfr_div.sv
rtl/core/direction_frame_rotation.sv
sim/tb_direction_frame_rotation.sv
